// ===== hdl/ucu8_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ucu8_pkg;

	localparam int unsigned BYTE_W       = 8;
	localparam int unsigned CODE_W       = 32;
	localparam int unsigned DIGIT_SLOTS  = 8;
	localparam int unsigned SLOT_W       = $clog2(DIGIT_SLOTS);
	localparam int unsigned SHORT_DIGITS = 4;
	localparam int unsigned LONG_DIGITS  = 8;
	localparam int unsigned DCOUNT_W     = 4;
	localparam int unsigned QUEUE_DEPTH  = 2;
	localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned PHASE_COUNT  = 5;

	localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [BYTE_W-1:0] CH_LOW_U  = 8'h75;
	localparam logic [BYTE_W-1:0] CH_UP_U   = 8'h55;

	typedef logic [BYTE_W-1:0]   byte_t;
	typedef logic [DCOUNT_W-1:0] dcount_t;
	typedef logic [CODE_W-1:0]   code_t;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_SLASH  = 2'd1,
		MODE_DIGITS = 2'd2
	} scan_mode_t;

	// emit order of one request; value equals its bit in the enable vector
	typedef enum logic [2:0] {
		PH_BS     = 3'd0,
		PH_LETTER = 3'd1,
		PH_DIGIT  = 3'd2,
		PH_UTF    = 3'd3,
		PH_TAIL   = 3'd4
	} phase_t;

	// one request from front to back
	typedef struct packed {
		logic                         bs_en;
		logic                         letter_en;
		logic                         long_form;
		dcount_t                      ndig;
		logic [DIGIT_SLOTS-1:0][BYTE_W-1:0] digits;
		logic                         utf_en;
		code_t                        code;
		logic                         tail_en;
		byte_t                        tail_byte;
		logic                         text_end;
	} cmd_t;

	// {valid, nibble}
	function automatic logic [4:0] hex_nibble(input byte_t b);
		logic [4:0] r;
		r = '0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, 4'(b - 8'h30)};
		end else if (b >= 8'h61 && b <= 8'h66) begin
			r = {1'b1, 4'(b - 8'h57)};
		end else if (b >= 8'h41 && b <= 8'h46) begin
			r = {1'b1, 4'(b - 8'h37)};
		end
		return r;
	endfunction

	// number of utf-8 bytes minus one
	function automatic logic [1:0] utf8_len(input code_t c);
		logic [1:0] r;
		if (c <= 32'h7F) begin
			r = 2'd0;
		end else if (c <= 32'h7FF) begin
			r = 2'd1;
		end else if (c <= 32'hFFFF) begin
			r = 2'd2;
		end else begin
			r = 2'd3;
		end
		return r;
	endfunction

	function automatic byte_t utf8_byte(input code_t c, input logic [1:0] idx);
		byte_t r;
		r = '0;
		unique case (utf8_len(c))
			2'd0: r = c[7:0];
			2'd1: r = (idx == 2'd0) ? {3'b110, c[10:6]} : {2'b10, c[5:0]};
			2'd2: begin
				unique case (idx)
					2'd0:    r = {4'b1110, c[15:12]};
					2'd1:    r = {2'b10, c[11:6]};
					default: r = {2'b10, c[5:0]};
				endcase
			end
			default: begin
				unique case (idx)
					2'd0:    r = 8'hF0 | c[25:18];
					2'd1:    r = {2'b10, c[17:12]};
					2'd2:    r = {2'b10, c[11:6]};
					default: r = {2'b10, c[5:0]};
				endcase
			end
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/universal_char_to_utf8_filter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   | dir | handshake          | payload
// ----------+-----+--------------------+------------------------------------------------
// source    | in  | s_tvalid/s_tready  | s_tdata[7:0] in_byte, s_tlast end_of_text
// result    | out | m_tvalid/m_tready  | m_tdata[7:0] out_byte, m_tuser run_last,
//           |     |                    | m_tlast text_last
//
// the front takes one source byte per cycle while the two-entry request queue has room
// the back drains one output byte per cycle while m_tready allows; an item yields 1 to 10
// result bytes through the single-byte output register (escape replays and utf-8 bursts)
// a byte that produces nothing (a held backslash, letter or digit) pushes no request
// reset is asynchronous and active low; it clears the scan state, queue and output valid
// either side may stall freely: the queue decouples front from back
module universal_char_to_utf8_filter_core (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire  [7:0] s_tdata,    // [7:0] in_byte
	input  wire        s_tlast,    // end_of_text
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata,    // [7:0] out_byte
	output logic       m_tuser,    // [0] run_last
	output logic       m_tlast     // text_last
);
	import ucu8_pkg::*;

	// request path from front to back
	logic q_full;
	logic push;
	cmd_t push_cmd;
	logic head_valid;
	cmd_t head;
	logic pop;

	// front: scan state, hex collection and request building
	ucu8_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// short queue so a long burst in the back does not stall the front at once
	ucu8_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	// back: walks each request byte by byte into the output register
	ucu8_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule
`default_nettype wire

// ===== hdl/ucu8_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ucu8_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 s_tvalid,
	output logic                s_tready,
	input  wire  [7:0]          s_tdata,
	input  wire                 s_tlast,
	input  wire                 q_full,
	output logic                push,
	output ucu8_pkg::cmd_t      push_cmd
);
	import ucu8_pkg::*;

	scan_mode_t mode_q, mode_d;
	logic       long_q, long_d;
	dcount_t    cnt_q, cnt_d, cnt_inc, need;
	code_t      code_q, code_d, code_inc;
	logic [DIGIT_SLOTS-1:0][BYTE_W-1:0] held_q, held_d;
	logic [4:0] hx;
	logic       is_hex, accept;
	cmd_t       cmd;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && !q_full;

	always_comb begin
		hx       = hex_nibble(s_tdata);
		is_hex   = hx[4];
		need     = long_q ? dcount_t'(LONG_DIGITS) : dcount_t'(SHORT_DIGITS);
		cnt_inc  = cnt_q + dcount_t'(1);
		code_inc = {code_q[CODE_W-5:0], hx[3:0]};
		held_d   = held_q;
		if (mode_q == MODE_DIGITS && is_hex) begin
			held_d[cnt_q[SLOT_W-1:0]] = s_tdata;
		end
		// most paths end back in idle
		mode_d = MODE_IDLE;
		long_d = 1'b0;
		cnt_d  = '0;
		code_d = '0;
		cmd           = '0;
		cmd.digits    = held_d;
		cmd.long_form = long_q;
		cmd.code      = code_inc;
		cmd.tail_byte = s_tdata;
		cmd.text_end  = s_tlast;
		unique case (mode_q)
			MODE_SLASH: begin
				if (s_tdata == CH_LOW_U || s_tdata == CH_UP_U) begin
					if (s_tlast) begin
						cmd.bs_en     = 1'b1;
						cmd.letter_en = 1'b1;
						cmd.long_form = (s_tdata == CH_UP_U);
					end else begin
						mode_d = MODE_DIGITS;
						long_d = (s_tdata == CH_UP_U);
					end
				end else begin
					cmd.bs_en   = 1'b1;
					cmd.tail_en = 1'b1;
				end
			end
			MODE_DIGITS: begin
				if (!is_hex) begin
					// replay what was held, then the breaking byte from idle
					cmd.bs_en     = 1'b1;
					cmd.letter_en = 1'b1;
					cmd.ndig      = cnt_q;
					if (s_tdata != CH_BSLASH || s_tlast) begin
						cmd.tail_en = 1'b1;
					end else begin
						mode_d = MODE_SLASH;
					end
				end else if (cnt_inc >= need) begin
					if (code_inc != '0) begin
						cmd.utf_en = 1'b1;
					end else begin
						cmd.bs_en     = 1'b1;
						cmd.letter_en = 1'b1;
						cmd.ndig      = cnt_inc;
					end
				end else if (s_tlast) begin
					cmd.bs_en     = 1'b1;
					cmd.letter_en = 1'b1;
					cmd.ndig      = cnt_inc;
				end else begin
					mode_d = MODE_DIGITS;
					long_d = long_q;
					cnt_d  = cnt_inc;
					code_d = code_inc;
				end
			end
			default: begin
				if (s_tdata == CH_BSLASH && !s_tlast) begin
					mode_d = MODE_SLASH;
				end else begin
					cmd.tail_en = 1'b1;
				end
			end
		endcase
	end

	assign push     = accept && (cmd.bs_en || cmd.letter_en || cmd.utf_en || cmd.tail_en);
	assign push_cmd = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			long_q <= 1'b0;
			cnt_q  <= '0;
			code_q <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			long_q <= long_d;
			cnt_q  <= cnt_d;
			code_q <= code_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_q <= held_d;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/ucu8_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ucu8_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  ucu8_pkg::cmd_t      push_cmd,
	input  wire                 pop,
	output logic                full,
	output logic                head_valid,
	output ucu8_pkg::cmd_t      head
);
	import ucu8_pkg::*;

	cmd_t                slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_pop;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/ucu8_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ucu8_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 head_valid,
	input  ucu8_pkg::cmd_t      head,
	output logic                pop,
	output logic                m_tvalid,
	input  wire                 m_tready,
	output logic [7:0]          m_tdata,
	output logic                m_tuser,
	output logic                m_tlast
);
	import ucu8_pkg::*;

	logic                   started_q;
	phase_t                 phase_q, cur_ph, first_ph, nxt_ph;
	logic [SLOT_W-1:0]      idx_q, cur_idx, nxt_idx;
	logic [PHASE_COUNT-1:0] en;
	logic                   first_fnd, nxt_fnd, last_in_phase, cmd_last, load;
	logic [1:0]             ulen;
	byte_t                  cur_byte;
	logic                   ovalid_q, orun_q, olast_q;
	byte_t                  odata_q;

	always_comb begin
		en = {head.tail_en, head.utf_en, (head.ndig != '0), head.letter_en, head.bs_en};
		first_ph  = PH_BS;
		first_fnd = 1'b0;
		for (int i = 0; i < PHASE_COUNT; i++) begin
			if (!first_fnd && en[i]) begin
				first_fnd = 1'b1;
				first_ph  = phase_t'(3'(i));
			end
		end
		cur_ph  = started_q ? phase_q : first_ph;
		cur_idx = started_q ? idx_q : '0;
		ulen    = utf8_len(head.code);

		unique case (cur_ph)
			PH_BS:     cur_byte = CH_BSLASH;
			PH_LETTER: cur_byte = head.long_form ? CH_UP_U : CH_LOW_U;
			PH_DIGIT:  cur_byte = head.digits[cur_idx];
			PH_UTF:    cur_byte = utf8_byte(head.code, cur_idx[1:0]);
			default:   cur_byte = head.tail_byte;
		endcase

		unique case (cur_ph)
			PH_DIGIT: last_in_phase = ((dcount_t'(cur_idx) + dcount_t'(1)) == head.ndig);
			PH_UTF:   last_in_phase = (cur_idx[1:0] == ulen);
			default:  last_in_phase = 1'b1;
		endcase

		nxt_ph  = cur_ph;
		nxt_idx = cur_idx + SLOT_W'(1);
		nxt_fnd = 1'b0;
		if (last_in_phase) begin
			nxt_idx = '0;
			for (int i = 0; i < PHASE_COUNT; i++) begin
				if (!nxt_fnd && en[i] && 3'(i) > cur_ph) begin
					nxt_fnd = 1'b1;
					nxt_ph  = phase_t'(3'(i));
				end
			end
		end
		cmd_last = last_in_phase && !nxt_fnd;
	end

	// output register loads from a valid head whenever it is empty or being drained
	assign load = head_valid && (!ovalid_q || m_tready);
	assign pop  = load && cmd_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			phase_q   <= PH_BS;
			idx_q     <= '0;
			ovalid_q  <= 1'b0;
		end else begin
			if (load) begin
				started_q <= !cmd_last;
				phase_q   <= nxt_ph;
				idx_q     <= nxt_idx;
			end
			if (!ovalid_q || m_tready) begin
				ovalid_q <= head_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			odata_q <= cur_byte;
			orun_q  <= cmd_last;
			olast_q <= cmd_last && head.text_end;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = odata_q;
	assign m_tuser  = orun_q;
	assign m_tlast  = olast_q;

endmodule
`default_nettype wire

// ===== hdl/ucu8_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ucu8_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       s_tvalid,
	input wire       s_tready,
	input wire [7:0] s_tdata,
	input wire       s_tlast,
	input wire       m_tvalid,
	input wire       m_tready,
	input wire [7:0] m_tdata,
	input wire       m_tuser,
	input wire       m_tlast
);

	// text end only ever closes a run
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("text end on a byte that is not last of its run");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// queue can only fill through an accepted source byte
	a_ready_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready && !s_tvalid |=> s_tready)
		else $error("ready dropped without a source request");

endmodule

bind universal_char_to_utf8_filter_core ucu8_checker u_ucu8_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire
